// File: rtl/rbw_pkg.sv
// Shared types and constants of the RBSP bit writer with Exp-Golomb coding.
`timescale 1ns / 1ps

package rbw_pkg;

  typedef enum logic [2:0] {
    FUNC_RAW    = 3'd0,
    FUNC_UE     = 3'd1,
    FUNC_SE     = 3'd2,
    FUNC_TRAIL  = 3'd3,
    FUNC_ZALIGN = 3'd4,
    FUNC_ALIGN  = 3'd5
  } func_e;

  localparam logic [7:0] ESCAPE_BYTE  = 8'h03;
  localparam logic [7:0] ESCAPE_LIMIT = 8'd4;

  localparam int SEG_DEPTH  = 2;
  localparam int SEG_PTR_W  = $clog2(SEG_DEPTH);
  localparam int SEG_CNT_W  = $clog2(SEG_DEPTH + 1);
  localparam int RES_DEPTH  = 2;
  localparam int RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

  // A run of bits to append: len bits, most significant first; positions above 31 are zero.
  typedef struct packed {
    logic [31:0] data;
    logic [6:0]  len;
  } seg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_escape;
    logic       last;
  } res_t;

endpackage

// File: rtl/rbw_front.sv
// Front end: accepts operations and turns each into a bit run of known length.
`timescale 1ns / 1ps

module rbw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          func_i,
  input  logic [31:0]         value_i,
  input  logic signed [31:0]  signed_value_i,
  input  logic [5:0]          bit_count_i,
  output logic                seg_push_o,
  output rbw_pkg::seg_t       seg_o,
  input  logic                seg_full_i
);
  import rbw_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  logic [2:0]  s1_func_q;
  logic [32:0] s1_x_q;
  logic [5:0]  s1_cnt_q;
  logic [2:0]  hold_q, hold_d;
  logic        accept;
  logic        s1_adv;
  logic [32:0] x_in;
  logic [31:0] neg_mag;
  logic [5:0]  lg;
  logic [6:0]  seg_len;
  logic [31:0] seg_data;
  logic [6:0]  trail_len;
  logic [31:0] trail_data;

  // Index of the most significant set bit, searched by byte group and then by bit.
  function automatic logic [5:0] msb_index(input logic [32:0] x);
    logic [39:0] xe;
    logic [2:0]  gsel;
    logic [2:0]  bsel;
    logic [7:0]  grp;
    xe   = {7'b0, x};
    gsel = 3'd0;
    bsel = 3'd0;
    for (int g = 0; g < 5; g++) begin
      if (|xe[g*8 +: 8]) begin
        gsel = 3'(g);
      end
    end
    grp = xe[gsel*8 +: 8];
    for (int b = 0; b < 8; b++) begin
      if (grp[b]) begin
        bsel = 3'(b);
      end
    end
    return {gsel, bsel};
  endfunction

  assign accept  = push && !full;
  assign neg_mag = ~signed_value_i + 32'd1;

  always_comb begin
    case (func_e'(func_i))
      FUNC_UE: begin
        x_in = {1'b0, value_i} + 33'd1;
      end
      FUNC_SE: begin
        if (signed_value_i > 32'sd0) begin
          x_in = {signed_value_i, 1'b0};
        end else begin
          x_in = {neg_mag, 1'b1};
        end
      end
      default: begin
        x_in = {1'b0, value_i};
      end
    endcase
  end

  assign lg         = msb_index(s1_x_q);
  assign trail_len  = 7'(4'd8 - {1'b0, hold_q});
  assign trail_data = 32'(8'h80 >> hold_q);

  always_comb begin
    seg_len  = 7'd0;
    seg_data = 32'd0;
    case (func_e'(s1_func_q))
      FUNC_RAW: begin
        seg_len  = 7'(s1_cnt_q);
        seg_data = s1_x_q[31:0];
      end
      FUNC_UE, FUNC_SE: begin
        seg_len  = {lg, 1'b1};
        seg_data = s1_x_q[31:0];
      end
      FUNC_TRAIL: begin
        seg_len  = trail_len;
        seg_data = trail_data;
      end
      FUNC_ZALIGN: begin
        seg_len  = (hold_q != 3'd0) ? trail_len : 7'd0;
      end
      FUNC_ALIGN: begin
        seg_len  = (hold_q != 3'd0) ? trail_len : 7'd0;
        seg_data = trail_data;
      end
      default: begin
        seg_len  = 7'd0;
      end
    endcase
  end

  assign s1_adv     = s1_valid_q && ((seg_len == 7'd0) || !seg_full_i);
  assign full       = s1_valid_q && !s1_adv;
  assign seg_push_o = s1_adv && (seg_len != 7'd0);
  assign seg_o      = '{data: seg_data, len: seg_len};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    hold_d = s1_adv ? hold_q + seg_len[2:0] : hold_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      hold_q     <= 3'd0;
    end else begin
      s1_valid_q <= s1_valid_d;
      hold_q     <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q <= func_i;
      s1_x_q    <= x_in;
      s1_cnt_q  <= bit_count_i;
    end
  end

endmodule

// File: rtl/rbw_seg_fifo.sv
// Short queue of bit runs between the front end and the byte packer.
`timescale 1ns / 1ps

module rbw_seg_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rbw_pkg::seg_t  data_i,
  output logic           full_o,
  input  logic           pop_i,
  output rbw_pkg::seg_t  data_o,
  output logic           empty_o
);
  import rbw_pkg::*;

  seg_t                 mem_q [SEG_DEPTH];
  logic [SEG_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [SEG_CNT_W-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == SEG_CNT_W'(SEG_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + SEG_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - SEG_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + SEG_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + SEG_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SEG_CNT_W'(SEG_DEPTH))
    else $error("segment queue holds more entries than its depth");

endmodule

// File: rtl/rbw_back.sv
// Back end: packs bit runs into bytes and inserts emulation prevention bytes.
`timescale 1ns / 1ps

module rbw_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rbw_pkg::seg_t  seg_i,
  input  logic           seg_empty_i,
  output logic           seg_pop_o,
  output logic           res_push_o,
  output rbw_pkg::res_t  res_o,
  input  logic           res_full_i
);
  import rbw_pkg::*;

  logic [6:0]  partial_q, partial_d;
  logic [2:0]  held_q, held_d;
  logic [1:0]  zero_run_q, zero_run_d;
  logic        started_q, started_d;
  logic [6:0]  rem_q, rem_d;
  logic [6:0]  cur_rem;
  logic [7:0]  sum;
  logic [39:0] window_ext;
  logic [7:0]  win;
  logic [14:0] hi_ext;
  logic [7:0]  byte_val;
  logic [6:0]  rem_next;
  logic        need_esc;
  logic [3:0]  absorb_sh;

  assign cur_rem    = started_q ? rem_q : seg_i.len;
  assign sum        = 8'(cur_rem) + 8'(held_q);
  assign window_ext = {seg_i.data, 8'b0} >> cur_rem;
  assign win        = window_ext[7:0];
  assign hi_ext     = {partial_q, 8'b0} >> held_q;
  assign byte_val   = hi_ext[7:0] | (win >> held_q);
  assign rem_next   = 7'(sum - 8'd8);
  assign need_esc   = (zero_run_q == 2'd2) && (byte_val < ESCAPE_LIMIT);
  assign absorb_sh  = 4'd8 - {1'b0, cur_rem[2:0]};

  always_comb begin
    partial_d  = partial_q;
    held_d     = held_q;
    zero_run_d = zero_run_q;
    started_d  = started_q;
    rem_d      = rem_q;
    seg_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{out_byte: byte_val, is_escape: 1'b0, last: rem_next < 7'd8};
    if (!seg_empty_i) begin
      if (sum >= 8'd8) begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (need_esc) begin
            res_o      = '{out_byte: ESCAPE_BYTE, is_escape: 1'b1, last: 1'b0};
            zero_run_d = 2'd0;
          end else begin
            zero_run_d = (byte_val == 8'd0) ? 2'(zero_run_q + 2'd1) : 2'd0;
            partial_d  = 7'd0;
            held_d     = 3'd0;
            rem_d      = rem_next;
            if (rem_next == 7'd0) begin
              seg_pop_o = 1'b1;
              started_d = 1'b0;
            end else begin
              started_d = 1'b1;
            end
          end
        end
      end else begin
        partial_d = 7'((partial_q << cur_rem[2:0]) | (win >> absorb_sh));
        held_d    = sum[2:0];
        seg_pop_o = 1'b1;
        started_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q  <= 7'd0;
      held_q     <= 3'd0;
      zero_run_q <= 2'd0;
      started_q  <= 1'b0;
      rem_q      <= 7'd0;
    end else begin
      partial_q  <= partial_d;
      held_q     <= held_d;
      zero_run_q <= zero_run_d;
      started_q  <= started_d;
      rem_q      <= rem_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_run_q != 2'd3)
    else $error("zero run passed two without an escape");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o && res_o.is_escape |=> zero_run_q == 2'd0)
    else $error("zero run not cleared after an escape beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> rem_q != 7'd0)
    else $error("run in progress with no bits left");

endmodule

// File: rtl/rbw_res_fifo.sv
// Output queue of finished bytes, so the packer runs on while the receiver stalls.
`timescale 1ns / 1ps

module rbw_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rbw_pkg::res_t  data_i,
  output logic           full_o,
  input  logic           pop_i,
  output rbw_pkg::res_t  data_o,
  output logic           empty_o
);
  import rbw_pkg::*;

  res_t                 mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [RES_CNT_W-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == RES_CNT_W'(RES_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + RES_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + RES_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + RES_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/rbsp_bit_writer_exp_golomb_unit.sv
// RBSP bit writer with Exp-Golomb coding and emulation prevention: top level.
//
// Operations enter through a queue-style port: an item is taken on a clock edge where
// push is high and full is low. Each one appends bits to the stream: raw bits, an
// unsigned or signed Exp-Golomb code, trailing bits or zero alignment. Completed bytes
// leave through a second queue-style port: the oldest byte is shown while empty is low
// and is taken on an edge where pop is high. A 0x03 byte is inserted, flagged by
// is_escape_o, after two zero bytes when the next byte is below four; last_o marks the
// final byte caused by an operation.
// The front end takes one operation per cycle unless the segment queue holds it back,
// and passes bit runs through a two-entry queue to the byte packer. The packer emits
// data and escape bytes one at a time and keeps bits that end part-way into a byte
// as a partial byte. A byte is registered in the front-end stage, the segment queue
// and the output queue before it is visible. When the receiver stalls, the two-entry
// output queue fills, the packer waits and full eventually rises; nothing is lost.
// Reset empties all queues and clears the partial byte and the zero-byte run.
`timescale 1ns / 1ps

module rbsp_bit_writer_exp_golomb_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         func_i,
  input  logic [31:0]        value_i,
  input  logic signed [31:0] signed_value_i,
  input  logic [5:0]         bit_count_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_byte_o,
  output logic               is_escape_o,
  output logic               last_o
);
  import rbw_pkg::*;

  seg_t seg_in, seg_out;
  logic seg_push, seg_full, seg_pop, seg_empty;
  res_t res_in, res_out;
  logic res_push, res_full;

  rbw_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .func_i         (func_i),
    .value_i        (value_i),
    .signed_value_i (signed_value_i),
    .bit_count_i    (bit_count_i),
    .seg_push_o     (seg_push),
    .seg_o          (seg_in),
    .seg_full_i     (seg_full)
  );

  rbw_seg_fifo u_seg_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (seg_push),
    .data_i  (seg_in),
    .full_o  (seg_full),
    .pop_i   (seg_pop),
    .data_o  (seg_out),
    .empty_o (seg_empty)
  );

  rbw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_i       (seg_out),
    .seg_empty_i (seg_empty),
    .seg_pop_o   (seg_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  rbw_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign out_byte_o  = res_out.out_byte;
  assign is_escape_o = res_out.is_escape;
  assign last_o      = res_out.last;

endmodule

// File: bench/tb.sv
// Testbench for the RBSP bit writer: a directed table, then random operations checked by a predictor.
`timescale 1ns / 1ps

module tb;
  import rbw_pkg::*;

  localparam logic [2:0] FUNC_SPARE6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE7 = 3'd7;
  localparam int RANDOM_OPS = 82;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] value;
    logic [31:0] sval;
    logic [5:0]  count;
    logic        known;
    logic [2:0]  n_known;
    logic [31:0] known_bytes;
    logic [3:0]  known_esc;
  } op_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               push           = 1'b0;
  logic               full;
  logic [2:0]         func_i         = '0;
  logic [31:0]        value_i        = '0;
  logic signed [31:0] signed_value_i = '0;
  logic [5:0]         bit_count_i    = '0;
  logic               empty;
  logic               pop            = 1'b0;
  logic [7:0]         out_byte_o;
  logic               is_escape_o;
  logic               last_o;

  op_t  table_ops[$];
  res_t op_bytes[$];
  res_t bytes_due[$];

  logic [7:0]  partial;
  int unsigned held;
  int unsigned zero_run;

  int unsigned n_err   = 0;
  int unsigned n_bytes = 0;
  int unsigned n_esc   = 0;
  int unsigned n_ops   = 0;
  bit          calm_tx = 1'b0;
  bit          calm_rx = 1'b0;

  rbsp_bit_writer_exp_golomb_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .func_i         (func_i),
    .value_i        (value_i),
    .signed_value_i (signed_value_i),
    .bit_count_i    (bit_count_i),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .is_escape_o    (is_escape_o),
    .last_o         (last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void leave_byte(logic [7:0] b);
    if (zero_run == 2 && b < ESCAPE_LIMIT) begin
      op_bytes.push_back({ESCAPE_BYTE, 1'b1, 1'b0});
      zero_run = 0;
    end
    zero_run = (b == 8'h00) ? zero_run + 1 : 0;
    op_bytes.push_back({b, 1'b0, 1'b0});
  endfunction

  function automatic void add_bit(logic b);
    partial = {partial[6:0], b};
    held++;
    if (held == 8) begin
      held = 0;
      leave_byte(partial);
    end
  endfunction

  function automatic void add_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) begin
      add_bit(i < 32 ? v[i] : 1'b0);
    end
  endfunction

  function automatic void add_golomb(logic [63:0] code);
    logic [63:0] x;
    int          lg;
    x  = code + 64'd1;
    lg = 0;
    while (lg < 63 && (x >> (lg + 1)) != 0) lg++;
    add_bits(x[31:0], 2 * lg + 1);
  endfunction

  function automatic void zero_pad();
    if (held != 0) add_bits(32'd0, 8 - held);
  endfunction

  function automatic void add_trailing();
    add_bit(1'b1);
    zero_pad();
  endfunction

  // Works out the bytes that one operation releases and queues them as due.
  function automatic void encode_op(op_t op);
    logic [63:0] mag;
    res_t        tail;
    op_bytes.delete();
    case (op.func)
      FUNC_RAW: add_bits(op.value, op.count);
      FUNC_UE: add_golomb({32'd0, op.value});
      FUNC_SE: begin
        mag = op.sval[31] ? {32'd0, ~op.sval + 32'd1} : {32'd0, op.sval};
        if (op.sval[31] || mag == 64'd0) add_golomb(mag << 1);
        else add_golomb((mag << 1) - 64'd1);
      end
      FUNC_TRAIL: add_trailing();
      FUNC_ZALIGN: zero_pad();
      FUNC_ALIGN: if (held != 0) add_trailing();
      default: ;
    endcase
    if (op.known) begin
      op_bytes.delete();
      for (int i = 0; i < op.n_known; i++) begin
        op_bytes.push_back({op.known_bytes[31 - 8 * i -: 8], op.known_esc[3 - i], 1'b0});
      end
    end
    if (op_bytes.size() > 0) begin
      tail      = op_bytes.pop_back();
      tail.last = 1'b1;
      op_bytes.push_back(tail);
    end
    foreach (op_bytes[i]) bytes_due.push_back(op_bytes[i]);
  endfunction

  function automatic void row(logic [2:0] f, logic [31:0] v, logic [31:0] s, logic [5:0] c,
                              int n, logic [31:0] kb, logic [3:0] ke);
    op_t op;
    op.func        = f;
    op.value       = v;
    op.sval        = s;
    op.count       = c;
    op.known       = (n >= 0);
    op.n_known     = (n < 0) ? 3'd0 : n[2:0];
    op.known_bytes = kb;
    op.known_esc   = ke;
    table_ops.push_back(op);
  endfunction

  function automatic op_t rand_op();
    op_t         op;
    int unsigned r;
    op.value       = $urandom;
    op.sval        = $urandom;
    op.count       = 6'($urandom_range(0, 63));
    op.known       = 1'b0;
    op.n_known     = '0;
    op.known_bytes = '0;
    op.known_esc   = '0;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      op.func  = FUNC_RAW;
      op.count = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(33, 63)
                                                  : $urandom_range(0, 32));
    end else if (r < 32) begin
      op.func  = FUNC_RAW;
      op.value = $urandom_range(0, 4);
      op.count = 6'(8 * $urandom_range(1, 4));
    end else if (r < 52) begin
      op.func  = FUNC_UE;
      if ($urandom_range(0, 19) != 0) op.value = op.value >> $urandom_range(4, 31);
    end else if (r < 70) begin
      op.func = FUNC_SE;
      op.sval = $signed(op.sval) >>> $urandom_range(0, 31);
    end else if (r < 78) begin
      op.func = FUNC_TRAIL;
    end else if (r < 86) begin
      op.func = FUNC_ZALIGN;
    end else if (r < 95) begin
      op.func = FUNC_ALIGN;
    end else begin
      op.func = r[0] ? FUNC_SPARE6 : FUNC_SPARE7;
    end
    return op;
  endfunction

  function automatic int pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Holds the beat until full is low at a clock edge.
  task automatic send_op(op_t op);
    int gap;
    gap = pick_gap(calm_tx);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push           <= 1'b1;
    func_i         <= op.func;
    value_i        <= op.value;
    signed_value_i <= op.sval;
    bit_count_i    <= op.count;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    encode_op(op);
    n_ops++;
  endtask

  function automatic void check_byte();
    res_t want;
    if (bytes_due.size() == 0) begin
      n_err++;
      if (n_err <= MAX_SHOWN) begin
        $display("tb: byte %02h esc %0b last %0b arrived with nothing due",
                 out_byte_o, is_escape_o, last_o);
      end
      return;
    end
    want = bytes_due.pop_front();
    n_bytes++;
    if (is_escape_o) n_esc++;
    if (out_byte_o !== want.out_byte || is_escape_o !== want.is_escape ||
        last_o !== want.last) begin
      n_err++;
      if (n_err <= MAX_SHOWN) begin
        $display("tb: byte %0d expected %02h esc %0b last %0b, got %02h esc %0b last %0b",
                 n_bytes, want.out_byte, want.is_escape, want.last,
                 out_byte_o, is_escape_o, last_o);
      end
    end
  endfunction

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) check_byte();
      if ($urandom_range(0, 199) == 0) calm_rx = !calm_rx;
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap(calm_rx);
      end
    end
  end

  initial begin
    row(FUNC_RAW,    32'h0000_00A5, 32'h0,         6'd8,  1, 32'hA500_0000, 4'b0000);
    row(FUNC_RAW,    32'hFFFF_FFFF, 32'h0,         6'd32, 4, 32'hFFFF_FFFF, 4'b0000);
    row(FUNC_RAW,    32'h1234_5678, 32'h0,         6'd0,  0, 32'h0,         4'b0000);
    row(FUNC_SPARE6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 0, 32'h0,         4'b0000);
    row(FUNC_SPARE7, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 6'd21, 0, 32'h0,         4'b0000);
    row(FUNC_TRAIL,  32'h0,         32'h0,         6'd0,  1, 32'h8000_0000, 4'b0000);
    row(FUNC_ZALIGN, 32'h0,         32'h0,         6'd0,  0, 32'h0,         4'b0000);
    row(FUNC_ALIGN,  32'h0,         32'h0,         6'd0,  0, 32'h0,         4'b0000);
    row(FUNC_RAW,    32'h0,         32'h0,         6'd16, 2, 32'h0,         4'b0000);
    row(FUNC_RAW,    32'h1,         32'h0,         6'd8,  2, 32'h0301_0000, 4'b1000);
    row(FUNC_RAW,    32'h0,         32'h0,         6'd16, 2, 32'h0,         4'b0000);
    row(FUNC_RAW,    32'h4,         32'h0,         6'd8,  1, 32'h0400_0000, 4'b0000);
    row(FUNC_RAW,    32'h0,         32'h0,         6'd16, 2, 32'h0,         4'b0000);
    row(FUNC_RAW,    32'h3,         32'h0,         6'd8,  2, 32'h0303_0000, 4'b1000);
    row(FUNC_UE,     32'h0,         32'h0,         6'd0,  0, 32'h0,         4'b0000);
    row(FUNC_ALIGN,  32'h0,         32'h0,         6'd0,  1, 32'hC000_0000, 4'b0000);
    row(FUNC_UE,     32'hFFFF_FFFF, 32'h0,         6'd0, -1, 32'h0,         4'b0000);
    row(FUNC_SE,     32'h0,         32'h8000_0000, 6'd0, -1, 32'h0,         4'b0000);
    row(FUNC_SE,     32'h0,         32'h7FFF_FFFF, 6'd0, -1, 32'h0,         4'b0000);
    row(FUNC_SE,     32'h0,         32'h8000_0001, 6'd0, -1, 32'h0,         4'b0000);
    row(FUNC_SE,     32'h0,         32'h1,         6'd0, -1, 32'h0,         4'b0000);
    row(FUNC_SE,     32'h0,         32'h0,         6'd0, -1, 32'h0,         4'b0000);
    row(FUNC_SE,     32'h0,         32'hFFFF_FFFF, 6'd0, -1, 32'h0,         4'b0000);
    row(FUNC_RAW,    32'hFFFF_FFFF, 32'h0,         6'd63, -1, 32'h0,        4'b0000);
    row(FUNC_UE,     32'hFFFF_FFFE, 32'h0,         6'd0, -1, 32'h0,         4'b0000);
    row(FUNC_ZALIGN, 32'h0,         32'h0,         6'd0, -1, 32'h0,         4'b0000);
    row(FUNC_UE,     32'h5,         32'h0,         6'd0, -1, 32'h0,         4'b0000);
    row(FUNC_TRAIL,  32'h0,         32'h0,         6'd0, -1, 32'h0,         4'b0000);

    partial  = '0;
    held     = 0;
    zero_run = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_ops[i]) send_op(table_ops[i]);
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 20 == 0) calm_tx = ($urandom_range(0, 3) == 0);
      if (i == 35 || i == 80) begin
        push <= 1'b0;
        @(posedge clk_i);
        while (bytes_due.size() != 0) @(posedge clk_i);
      end
      send_op(rand_op());
    end
    push <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("tb: %0d operations sent (%0d from the table), %0d bytes checked, %0d escapes",
             n_ops, table_ops.size(), n_bytes, n_esc);
    $display("tb: %0d mismatches or stray bytes", n_err);
    if (n_err == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: timed out with %0d bytes still due", bytes_due.size());
    $display("tb: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
rtl/rbw_pkg.sv
rtl/rbw_front.sv
rtl/rbw_seg_fifo.sv
rtl/rbw_back.sv
rtl/rbw_res_fifo.sv
rtl/rbsp_bit_writer_exp_golomb_unit.sv
bench/tb.sv
